// ===== sv/sliding_window_distinct_count_defines.svh =====
// Assertion macros shared by the sliding window distinct count RTL.
`ifndef SLIDING_WINDOW_DISTINCT_COUNT_DEFINES_SVH
`define SLIDING_WINDOW_DISTINCT_COUNT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define SWDC_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("swdc assertion failed");

// Next-cycle implication, checked outside reset.
`define SWDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("swdc assertion failed");

`else

`define SWDC_ASSERT(label, clk, rstn, ante, cons)
`define SWDC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/swdc_pkg.sv =====
// Shared constants for the sliding window distinct count block.
package swdc_pkg;

    localparam int WINDOW_MAX_DEF = 1024;
    localparam int VALUE_BITS_DEF = 16;

    localparam int IN_W   = 16;   // width of the value port
    localparam int CNT_W  = 11;   // occurrence counts, running total, result
    localparam int WS_W   = 11;   // window_size register
    localparam int CFG_DW = 32;   // APB data width
    localparam int ADDR_W = 3;    // APB address width

    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

    localparam int OUT_DEPTH = 2; // result buffer entries
    localparam int PEND_W    = 2; // holds 0..OUT_DEPTH

endpackage

// ===== sv/swdc_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module swdc_ram #(
    parameter int DW    = 16,
    parameter int AW    = 10,
    parameter int DEPTH = 1024
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] ram_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // a read of the entry being written returns the old contents
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/swdc_out_fifo.sv =====
// Two-entry result buffer between the update pipeline and the result channel.
module swdc_out_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic                     push,
    input  logic [swdc_pkg::CNT_W-1:0] push_data,
    input  logic                     pop,
    output logic                     out_valid,
    output logic [swdc_pkg::CNT_W-1:0] out_data
);

    logic [swdc_pkg::CNT_W-1:0]  data_reg [swdc_pkg::OUT_DEPTH];
    logic                        wr_ptr_reg, wr_ptr_next;
    logic                        rd_ptr_reg, rd_ptr_next;
    logic [swdc_pkg::PEND_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + swdc_pkg::PEND_W'(push) - swdc_pkg::PEND_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = data_reg[rd_ptr_reg];

endmodule

// ===== sv/sliding_window_distinct_count.sv =====
// Sliding window distinct count: accepts one value per transfer and reports the number of
// distinct values among the last window_size values once the window is full. Values sit in a
// delay line RAM of WINDOW_MAX entries; one occurrence count per possible value sits in a count
// RAM of 2^VALUE_BITS entries. Each item takes two read-modify-write passes on the count RAM
// (the value leaving the window, then the value entering it), so s_ready is low while an item
// is in p1, but the next item may enter before the last result is out. A result passes p1, p2,
// p3 and the result buffer to m_valid. A two-entry result buffer lets the next item enter while
// a result waits. After reset and after every write to window_size the count RAM is cleared one
// entry per cycle over all 2^VALUE_BITS entries, with s_ready low; the window then restarts
// empty. window_size 0 acts as 1, and values above WINDOW_MAX act as WINDOW_MAX.
`include "sliding_window_distinct_count_defines.svh"

module sliding_window_distinct_count #(
    parameter int WINDOW_MAX = swdc_pkg::WINDOW_MAX_DEF,
    parameter int VALUE_BITS = swdc_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swdc_pkg::ADDR_W-1:0]   paddr,
    input  logic [swdc_pkg::CFG_DW-1:0]   pwdata,
    output logic [swdc_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [swdc_pkg::IN_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [swdc_pkg::CNT_W-1:0]    m_distinct_count
);

    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = swdc_pkg::CNT_W;

    // configuration
    logic                      ws_wr;
    logic [swdc_pkg::WS_W-1:0] ws_reg;
    logic [31:0]               ws32, k32;

    // clearing sweep over the count RAM
    logic                  clr_busy_reg;
    logic [VALUE_BITS-1:0] clr_addr_reg;

    // window bookkeeping
    logic [PW-1:0] wp_reg, wp_next;
    logic [KW-1:0] fill_reg, fill_next;
    logic [31:0]   wp32, fill32, fill_inc32, slot32;
    logic          evict, emit;
    logic [31:0]   in32;
    logic [VALUE_BITS-1:0] in_val;

    logic s_xfer, m_xfer;

    // update pipeline
    logic                  p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [VALUE_BITS-1:0] p1_value_reg, p2_value_reg, p3_value_reg;
    logic                  p1_evict_reg, p2_evict_reg;
    logic                  p1_emit_reg, p2_emit_reg, p3_emit_reg;
    logic [VALUE_BITS-1:0] p2_old_reg;
    logic [VALUE_BITS-1:0] old_val;

    // RAM ports
    logic [VALUE_BITS-1:0] dl_rd_data;
    logic                  cnt_rd_en;
    logic [VALUE_BITS-1:0] cnt_rd_addr;
    logic [CW-1:0]         cnt_rd_data;
    logic                  cw_en;
    logic [VALUE_BITS-1:0] cw_addr;
    logic [CW-1:0]         cw_data;
    logic                  ram_wr_en;
    logic [VALUE_BITS-1:0] ram_wr_addr;
    logic [CW-1:0]         ram_wr_data;
    logic                  fwd_hit_reg;
    logic [CW-1:0]         fwd_data_reg;
    logic [CW-1:0]         cd;
    logic                  dec_en;

    // running total and results
    logic [CW-1:0]               total_reg, total_next;
    logic                        push;
    logic [CW-1:0]               push_data;
    logic [swdc_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic                        drop;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign ws_wr  = psel && penable && pwrite && (paddr[2] == swdc_pkg::REG_WINDOW_SIZE);
    assign prdata = (paddr[2] == swdc_pkg::REG_WINDOW_SIZE)
                  ? {{(swdc_pkg::CFG_DW - swdc_pkg::WS_W){1'b0}}, ws_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg <= swdc_pkg::WS_W'(1);
        end else if (ws_wr) begin
            ws_reg <= pwdata[swdc_pkg::WS_W-1:0];
        end
    end

    assign ws32 = 32'(ws_reg);
    assign k32  = (ws32 == 32'd0) ? 32'd1
                : (ws32 > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : ws32;

    // ---------------- clearing sweep ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn || ws_wr) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------- input side ----------------
    assign m_xfer  = m_valid && m_ready;
    assign s_ready = !clr_busy_reg && !p1_valid_reg
                  && ((pend_reg < swdc_pkg::PEND_W'(swdc_pkg::OUT_DEPTH)) || m_xfer);
    assign s_xfer  = s_valid && s_ready;

    assign in32   = 32'(s_value);
    assign in_val = in32[VALUE_BITS-1:0];

    always_comb begin
        wp32       = 32'(wp_reg);
        fill32     = 32'(fill_reg);
        evict      = (fill32 >= k32);
        fill_inc32 = evict ? fill32 : fill32 + 32'd1;
        emit       = (fill_inc32 >= k32);
        fill_next  = fill_inc32[KW-1:0];
        // oldest slot of the window: wp - k modulo WINDOW_MAX
        slot32     = wp32 + 32'(WINDOW_MAX) - k32;
        if (slot32 >= 32'(WINDOW_MAX)) begin
            slot32 = slot32 - 32'(WINDOW_MAX);
        end
        wp_next = (wp32 == 32'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ws_wr) begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (s_xfer) begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // delay line: write the new value, read the one leaving the window
    swdc_ram #(
        .DW    (VALUE_BITS),
        .AW    (PW),
        .DEPTH (WINDOW_MAX)
    ) u_delay_ram (
        .aclk    (aclk),
        .wr_en   (s_xfer),
        .wr_addr (wp_reg),
        .wr_data (in_val),
        .rd_en   (s_xfer),
        .rd_addr (slot32[PW-1:0]),
        .rd_data (dl_rd_data)
    );

    // ---------------- update pipeline ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn || ws_wr) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_xfer;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    assign old_val = dl_rd_data;

    always_ff @(posedge aclk) begin
        p1_value_reg <= in_val;
        p1_evict_reg <= evict;
        p1_emit_reg  <= emit;
        p2_value_reg <= p1_value_reg;
        p2_old_reg   <= old_val;
        p2_evict_reg <= p1_evict_reg;
        p2_emit_reg  <= p1_emit_reg;
        p3_value_reg <= p2_value_reg;
        p3_emit_reg  <= p2_emit_reg;
    end

    // count RAM reads: leaving value in stage 1, entering value in stage 2
    assign cnt_rd_en   = p1_valid_reg || p2_valid_reg;
    assign cnt_rd_addr = p1_valid_reg ? old_val : p2_value_reg;

    // take the word written in the same cycle as the read
    assign cd = fwd_hit_reg ? fwd_data_reg : cnt_rd_data;

    assign dec_en = p2_valid_reg && p2_evict_reg && (cd != '0);

    always_comb begin
        if (p2_valid_reg) begin
            cw_en   = dec_en;
            cw_addr = p2_old_reg;
            cw_data = cd - 1'b1;
        end else begin
            cw_en   = p3_valid_reg;
            cw_addr = p3_value_reg;
            cw_data = cd + 1'b1;
        end
    end

    assign ram_wr_en   = clr_busy_reg || cw_en;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : cw_addr;
    assign ram_wr_data = clr_busy_reg ? '0 : cw_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= ram_wr_en && cnt_rd_en && (ram_wr_addr == cnt_rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= ram_wr_data;
    end

    swdc_ram #(
        .DW    (CW),
        .AW    (VALUE_BITS),
        .DEPTH (1 << VALUE_BITS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    // ---------------- running total ----------------
    always_comb begin
        total_next = total_reg;
        if (dec_en && (cd == CW'(1)) && (total_reg != '0)) begin
            total_next = total_reg - 1'b1;
        end
        if (p3_valid_reg && (cd == '0)) begin
            total_next = total_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ws_wr) begin
            total_reg <= '0;
        end else begin
            total_reg <= total_next;
        end
    end

    // ---------------- results ----------------
    assign push      = p3_valid_reg && p3_emit_reg;
    assign push_data = total_next;
    assign drop      = p3_valid_reg && !p3_emit_reg;

    // items in flight plus results held
    assign pend_next = pend_reg + swdc_pkg::PEND_W'(s_xfer)
                     - swdc_pkg::PEND_W'(m_xfer) - swdc_pkg::PEND_W'(drop);

    always_ff @(posedge aclk) begin
        if (!aresetn || ws_wr) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    swdc_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (ws_wr),
        .push      (push),
        .push_data (push_data),
        .pop       (m_xfer),
        .out_valid (m_valid),
        .out_data  (m_distinct_count)
    );

    // ---------------- assertions ----------------
    `SWDC_ASSERT(a_pend_bound, aclk, aresetn, 1'b1, pend_reg <= swdc_pkg::PEND_W'(swdc_pkg::OUT_DEPTH))
    `SWDC_ASSERT_NEXT(a_accept_spacing, aclk, aresetn, s_xfer, !s_ready)
    `SWDC_ASSERT(a_no_update_in_clear, aclk, aresetn, clr_busy_reg, !(p2_valid_reg || p3_valid_reg))
    `SWDC_ASSERT(a_result_nonzero, aclk, aresetn, push, push_data != '0)

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the sliding window distinct count block.
module tb;

    localparam int IN_W          = swdc_pkg::IN_W;
    localparam int CNT_W         = swdc_pkg::CNT_W;
    localparam int WS_W          = swdc_pkg::WS_W;
    localparam int CFG_DW        = swdc_pkg::CFG_DW;
    localparam int ADDR_W        = swdc_pkg::ADDR_W;
    localparam int WMAX          = swdc_pkg::WINDOW_MAX_DEF;
    localparam int VSPAN         = 1 << swdc_pkg::VALUE_BITS_DEF;
    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 2_500_000;
    localparam int MAX_PRINTS    = 20;
    localparam int IDLE_PERCENT  = 28;

    localparam logic [ADDR_W-1:0] ADDR_WINDOW_SIZE = ADDR_W'(4 * swdc_pkg::REG_WINDOW_SIZE);
    localparam logic [ADDR_W-1:0] ADDR_SPARE       = ADDR_W'(4 * (swdc_pkg::REG_WINDOW_SIZE + 1));
    localparam logic [CFG_DW-1:0] WS_ALL_ONES      = CFG_DW'((1 << WS_W) - 1);

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [IN_W-1:0]   s_value;
    logic              m_valid;
    logic              m_ready;
    logic [CNT_W-1:0]  m_distinct_count;

    // Predictor state: window register, delay line, per-value tallies.
    logic [WS_W-1:0]  window_reg;
    logic [IN_W-1:0]  recent [WMAX];
    int unsigned      tally [VSPAN];
    int unsigned      distinct_now;
    int unsigned      fill;
    int unsigned      wpos;
    logic [CNT_W-1:0] pending_counts [$];
    logic [CNT_W-1:0] want_count;

    int errors;
    int items_sent;
    int counts_checked;
    int reg_writes;
    bit steady;

    sliding_window_distinct_count dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_distinct_count (m_distinct_count)
    );

    initial aclk = 1'b0;
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < VSPAN; i++) tally[i] = 0;
        distinct_now = 0;
        fill = 0;
        wpos = 0;
    endfunction

    function automatic int unsigned window_len();
        if (window_reg == 0) return 1;
        if (window_reg > WMAX) return WMAX;
        return window_reg;
    endfunction

    // Retire the oldest value once the window is full, then admit v.
    function automatic void advance_window(logic [IN_W-1:0] v);
        int unsigned k;
        int unsigned slot;
        int unsigned old;
        k = window_len();
        if (fill >= k) begin
            slot = (wpos + WMAX - k) % WMAX;
            old = recent[slot];
            if (tally[old] > 0) begin
                tally[old]--;
                if (tally[old] == 0 && distinct_now > 0) distinct_now--;
            end
        end
        recent[wpos] = v;
        wpos = (wpos + 1) % WMAX;
        if (tally[v] == 0) distinct_now++;
        tally[v]++;
        if (fill < k) fill++;
        if (fill >= k) pending_counts = {pending_counts, CNT_W'(distinct_now)};
    endfunction

    // Mostly a small alphabet so values repeat, sometimes anything or near the top.
    function automatic logic [IN_W-1:0] pick_value(int unsigned span);
        case ($urandom_range(0, 9))
            0: begin
                return IN_W'($urandom);
            end
            1: begin
                return IN_W'(VSPAN - 1 - $urandom_range(0, span - 1));
            end
            default: begin
                return IN_W'($urandom_range(0, span - 1));
            end
        endcase
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        end
    endtask

    // Hold valid and the value until the transfer; valid drops only on a gap.
    task automatic send_value(logic [IN_W-1:0] v);
        if (idle_now()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (idle_now());
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        advance_window(v);
        items_sent++;
    endtask

    // Drop valid and wait out the outstanding results plus pipeline latency.
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register, then read window_size back.
    task automatic set_register(logic [ADDR_W-1:0] addr, logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_WINDOW_SIZE) begin
            window_reg = data[WS_W-1:0];
            clear_window();
        end
        reg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW_SIZE;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== CFG_DW'(window_reg)) flag_mismatch("window_size readback", prdata, window_reg);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: check each transfer, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                flag_mismatch("unexpected result", m_distinct_count, -1);
            end else begin
                want_count = pending_counts.pop_front();
                counts_checked++;
                if (m_distinct_count !== want_count) begin
                    flag_mismatch("distinct_count", m_distinct_count, want_count);
                end
            end
        end
        m_ready <= !idle_now();
    end

    // Reset window of one: every item reports 1; a write to the spare address is dropped.
    task automatic test_reset_window();
        logic [IN_W-1:0] vals [8];
        vals = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h8000, 16'h0001};
        set_register(ADDR_SPARE, 32'hFFFF_FFFF);
        foreach (vals[i]) send_value(vals[i]);
        finish_phase();
    endtask

    // Window size zero acts as one.
    task automatic test_window_zero();
        set_register(ADDR_WINDOW_SIZE, '0);
        send_value(16'h0000);
        send_value(16'h0000);
        send_value(16'h0007);
        send_value(16'hFFFF);
        finish_phase();
    endtask

    // Counts that fall to zero and stay nonzero; a rewrite restarts the window.
    task automatic test_short_window();
        logic [IN_W-1:0] vals [8];
        vals = '{16'h0001, 16'h0002, 16'h0001, 16'h0001, 16'h0003, 16'h0003, 16'h0003, 16'hFFFF};
        set_register(ADDR_WINDOW_SIZE, CFG_DW'(3));
        foreach (vals[i]) send_value(vals[i]);
        finish_phase();
        set_register(ADDR_WINDOW_SIZE, CFG_DW'(3));
        send_value(16'hFFFF);
        send_value(16'h0001);
        send_value(16'hFFFF);
        finish_phase();
    endtask

    // Several small windows with random contents.
    task automatic test_random_small();
        int unsigned w;
        int unsigned span;
        logic [CFG_DW-1:0] data;
        for (int s = 0; s < 4; s++) begin
            w = $urandom_range(2, 40);
            span = $urandom_range(1, 2 * w + 2);
            data = CFG_DW'(w);
            // upper bits of the write data are don't-care
            if (s == 1) data = ($urandom & ~WS_ALL_ONES) | CFG_DW'(w);
            set_register(ADDR_WINDOW_SIZE, data);
            for (int i = 0; i < 60; i++) begin
                send_value(pick_value(span));
                if (s == 2 && i == 44) begin
                    finish_phase();
                    set_register(ADDR_SPARE, $urandom);
                end
            end
            finish_phase();
        end
    endtask

    // Largest window while it fills: no result may appear yet.
    task automatic test_window_max();
        set_register(ADDR_WINDOW_SIZE, CFG_DW'(WMAX));
        for (int i = 0; i < 40; i++) send_value(pick_value(1200));
        finish_phase();
    endtask

    // All register bits set saturates to the largest window; all distinct fills it,
    // with a long stretch of no idling on either side.
    task automatic test_window_saturated();
        set_register(ADDR_WINDOW_SIZE, WS_ALL_ONES);
        for (int i = 0; i < WMAX; i++) begin
            steady = (i >= 300 && i < 700);
            send_value(IN_W'(i * 61));
        end
        steady = 1'b0;
        for (int i = 0; i < 16; i++) send_value(pick_value(8));
        finish_phase();
    endtask

    initial begin
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_valid        <= 1'b0;
        s_value        <= '0;
        m_ready        <= 1'b0;
        errors         = 0;
        items_sent     = 0;
        counts_checked = 0;
        reg_writes     = 0;
        steady         = 1'b0;
        window_reg     = WS_W'(1);
        clear_window();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_window();
        test_window_zero();
        test_short_window();
        test_random_small();
        test_window_max();
        test_window_saturated();

        $display("Sent %0d values through %0d register writes, window sizes 0 to 2047",
                 items_sent, reg_writes);
        $display("Checked %0d distinct counts", counts_checked);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/swdc_pkg.sv
sv/swdc_ram.sv
sv/swdc_out_fifo.sv
sv/sliding_window_distinct_count.sv
sim/tb.sv
